// ===== hw/rtl/cau_pkg.sv =====
// ---------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and the saturation helper of the complex unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam int WORD_BITS   = 32;
	localparam int FRAC_BITS   = 16;
	localparam int PROD_BITS   = 2 * WORD_BITS;
	localparam int EXT_BITS    = PROD_BITS + 2;
	localparam int QUO_BITS    = WORD_BITS + 1;
	localparam int ROOT_BITS   = WORD_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 2;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_CONJ = 3'd4,
		OP_NEG  = 3'd5,
		OP_MAG  = 3'd6,
		OP_NONE = 3'd7
	} cau_op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} cau_status_t;

	typedef logic signed [WORD_BITS-1:0] cau_word_t;

	// classified word passed from front to back
	typedef struct packed {
		cau_op_t   op;
		logic      div0;
		cau_word_t a_re;
		cau_word_t a_im;
		cau_word_t b_re;
		cau_word_t b_im;
		cau_word_t sq_x;
		cau_word_t sq_y;
	} cau_item_t;

	typedef struct packed {
		logic      sat;
		cau_word_t val;
	} cau_sat_t;

	localparam logic signed [EXT_BITS-1:0] WMAX =
		(EXT_BITS'(1) <<< (WORD_BITS - 1)) - EXT_BITS'(1);
	localparam logic signed [EXT_BITS-1:0] WMIN = -WMAX - EXT_BITS'(1);

	// clamp a wide signed value to the word range
	function automatic cau_sat_t sat_word(input logic signed [EXT_BITS-1:0] v);
		cau_sat_t r;
		r.sat = 1'b0;
		r.val = v[WORD_BITS-1:0];
		if (v > WMAX) begin
			r.sat = 1'b1;
			r.val = WMAX[WORD_BITS-1:0];
		end else if (v < WMIN) begin
			r.sat = 1'b1;
			r.val = WMIN[WORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cau_fifo.sv =====
// ---------------------------------------------------------------------------
// cau_fifo
// Small register queue with full and empty flags; depth a power of two.
// ---------------------------------------------------------------------------
`default_nettype none

module cau_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + 1'b1;
			if (do_rd) rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
// ---------------------------------------------------------------------------
// cau_front
// Takes input words, decodes the operation and flags division by zero.
// ---------------------------------------------------------------------------
`default_nettype none

module cau_front import cau_pkg::*; (
	input  logic            push,
	output logic            full,
	input  logic [2:0]      req_type,
	input  cau_word_t       a_re,
	input  cau_word_t       a_im,
	input  cau_word_t       b_re,
	input  cau_word_t       b_im,
	input  logic            q_full,
	output logic            q_wr,
	output cau_item_t       q_item
);

	cau_op_t op;

	assign op    = cau_op_t'(req_type);
	assign full  = q_full;
	assign q_wr  = push && !q_full;

	// classify and choose the operands of the squaring multipliers
	always_comb begin
		q_item.op   = op;
		q_item.div0 = (op == OP_DIV) && (b_re == '0) && (b_im == '0);
		q_item.a_re = a_re;
		q_item.a_im = a_im;
		q_item.b_re = b_re;
		q_item.b_im = b_im;
		q_item.sq_x = (op == OP_MAG) ? a_re : b_re;
		q_item.sq_y = (op == OP_MAG) ? a_im : b_im;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_back.sv =====
// ---------------------------------------------------------------------------
// cau_back
// Execution pipeline: products, sums, 33-step divider and square root.
// ---------------------------------------------------------------------------
`default_nettype none

module cau_back import cau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_empty,
	input  cau_item_t   in_item,
	output logic        in_rd,
	input  logic        out_full,
	output logic        out_wr,
	output cau_word_t   out_re,
	output cau_word_t   out_im,
	output cau_status_t out_status
);

	localparam int NST = QUO_BITS;
	localparam int RW  = ROOT_BITS + 4;

	typedef struct packed {
		logic                neg;
		logic                ovf;
		logic [PROD_BITS-1:0] r;
		logic [QUO_BITS-1:0]  x;
		logic [QUO_BITS-1:0]  q;
	} div_t;

	typedef struct packed {
		cau_op_t              op;
		logic                 div0;
		cau_word_t            qre;
		cau_word_t            qim;
		logic                 qsat;
		logic [PROD_BITS-1:0] den;
		div_t                 dre;
		div_t                 dim;
		logic [PROD_BITS-1:0] sx;
		logic [RW-1:0]        srem;
		logic [ROOT_BITS-1:0] root;
	} it_t;

	function automatic div_t div_init(input logic signed [EXT_BITS-1:0] n,
			input logic [PROD_BITS-1:0] den);
		div_t                           d;
		logic signed [EXT_BITS-1:0]     m;
		logic [PROD_BITS-1:0]           nm;
		logic [PROD_BITS+FRAC_BITS-1:0] xw;
		d.neg = n[EXT_BITS-1];
		m     = d.neg ? -n : n;
		nm    = m[PROD_BITS-1:0];
		xw    = {nm, {FRAC_BITS{1'b0}}};
		d.r   = nm >> (QUO_BITS - FRAC_BITS);
		d.ovf = d.r >= den;
		d.x   = xw[QUO_BITS-1:0];
		d.q   = '0;
		return d;
	endfunction

	function automatic div_t div_step(input div_t d, input logic [PROD_BITS-1:0] den);
		div_t               o;
		logic [PROD_BITS:0] r2;
		logic [PROD_BITS:0] df;
		logic               ge;
		r2    = {d.r, d.x[QUO_BITS-1]};
		df    = r2 - {1'b0, den};
		ge    = r2 >= {1'b0, den};
		o     = d;
		o.r   = ge ? df[PROD_BITS-1:0] : r2[PROD_BITS-1:0];
		o.x   = d.x << 1;
		o.q   = {d.q[QUO_BITS-2:0], ge};
		return o;
	endfunction

	function automatic cau_sat_t div_final(input div_t d);
		cau_sat_t            r;
		logic [QUO_BITS-1:0] lim;
		logic [QUO_BITS-1:0] qq;
		lim   = d.neg ? (QUO_BITS'(1) << (WORD_BITS - 1))
		              : (QUO_BITS'(1) << (WORD_BITS - 1)) - QUO_BITS'(1);
		r.sat = d.ovf || (d.q > lim);
		qq    = r.sat ? lim : d.q;
		qq    = d.neg ? -qq : qq;
		r.val = qq[WORD_BITS-1:0];
		return r;
	endfunction

	logic                        adv;
	logic                        v_s1;
	cau_item_t                   item_s1;
	logic signed [PROD_BITS-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic                        v_s2;
	cau_op_t                     op_s2;
	logic                        div0_s2;
	cau_word_t                   qre_s2, qim_s2;
	logic                        qsat_s2;
	logic signed [EXT_BITS-1:0]  nre_s2, nim_s2;
	logic [PROD_BITS-1:0]        den_s2;
	logic                        v_s3 [NST];
	it_t                         it_s3 [NST];
	it_t                         nxt [NST];
	it_t                         init_c;
	logic signed [EXT_BITS-1:0]  ar, ai, br, bi, mre, mim;
	cau_sat_t                    sr, si;
	it_t                         fin;
	cau_sat_t                    fre, fim;

	assign adv   = !(v_s3[NST-1] && out_full);
	assign in_rd = adv && !in_empty;

	// valid bits of every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int k = 0; k < NST; k++) v_s3[k] <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_rd;
			v_s2    <= v_s1;
			v_s3[0] <= v_s2;
			for (int k = 1; k < NST; k++) v_s3[k] <= v_s3[k-1];
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
			p0_s1   <= in_item.a_re * in_item.b_re;
			p1_s1   <= in_item.a_im * in_item.b_im;
			p2_s1   <= in_item.a_re * in_item.b_im;
			p3_s1   <= in_item.a_im * in_item.b_re;
			p4_s1   <= in_item.sq_x * in_item.sq_x;
			p5_s1   <= in_item.sq_y * in_item.sq_y;
		end
	end

	// sums and the short operations
	always_comb begin
		ar  = EXT_BITS'(item_s1.a_re);
		ai  = EXT_BITS'(item_s1.a_im);
		br  = EXT_BITS'(item_s1.b_re);
		bi  = EXT_BITS'(item_s1.b_im);
		mre = EXT_BITS'(p0_s1) - EXT_BITS'(p1_s1);
		mim = EXT_BITS'(p2_s1) + EXT_BITS'(p3_s1);
		sr  = '0;
		si  = '0;
		unique case (item_s1.op)
			OP_ADD: begin
				sr = sat_word(ar + br);
				si = sat_word(ai + bi);
			end
			OP_SUB: begin
				sr = sat_word(ar - br);
				si = sat_word(ai - bi);
			end
			OP_MUL: begin
				sr = sat_word(mre >>> FRAC_BITS);
				si = sat_word(mim >>> FRAC_BITS);
			end
			OP_CONJ: begin
				sr = sat_word(ar);
				si = sat_word(-ai);
			end
			OP_NEG: begin
				sr = sat_word(-ar);
				si = sat_word(-ai);
			end
			default: begin
				sr = '0;
				si = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= item_s1.op;
			div0_s2 <= item_s1.div0;
			qre_s2  <= sr.val;
			qim_s2  <= si.val;
			qsat_s2 <= sr.sat || si.sat;
			nre_s2  <= EXT_BITS'(p0_s1) + EXT_BITS'(p1_s1);
			nim_s2  <= EXT_BITS'(p3_s1) - EXT_BITS'(p2_s1);
			den_s2  <= unsigned'(p4_s1) + unsigned'(p5_s1);
		end
	end

	// setup of the digit pipeline
	always_comb begin
		init_c      = '0;
		init_c.op   = op_s2;
		init_c.div0 = div0_s2;
		init_c.qre  = qre_s2;
		init_c.qim  = qim_s2;
		init_c.qsat = qsat_s2;
		init_c.den  = den_s2;
		init_c.dre  = div_init(nre_s2, den_s2);
		init_c.dim  = div_init(nim_s2, den_s2);
		init_c.sx   = den_s2;
	end

	// one quotient bit per stage for both parts, one root bit while any remain
	for (genvar j = 0; j < NST; j++) begin : g_stage
		it_t           src;
		logic [RW-1:0] rr;
		logic [RW-1:0] trial;
		logic          sge;
		if (j == 0) begin : g_first
			assign src = init_c;
		end else begin : g_rest
			assign src = it_s3[j-1];
		end
		assign rr    = {src.srem[RW-3:0], src.sx[PROD_BITS-1 -: 2]};
		assign trial = {2'b00, src.root, 2'b01};
		assign sge   = rr >= trial;
		always_comb begin
			nxt[j]     = src;
			nxt[j].dre = div_step(src.dre, src.den);
			nxt[j].dim = div_step(src.dim, src.den);
			if (j < ROOT_BITS) begin
				nxt[j].srem = sge ? rr - trial : rr;
				nxt[j].root = {src.root[ROOT_BITS-2:0], sge};
				nxt[j].sx   = src.sx << 2;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) it_s3[j] <= nxt[j];
		end
	end

	// result selection
	assign fin = it_s3[NST-1];
	assign fre = div_final(fin.dre);
	assign fim = div_final(fin.dim);
	assign out_wr = v_s3[NST-1] && !out_full;

	always_comb begin
		out_re     = fin.qre;
		out_im     = fin.qim;
		out_status = fin.qsat ? ST_SAT : ST_OK;
		priority if (fin.op == OP_DIV && fin.div0) begin
			out_re     = '0;
			out_im     = '0;
			out_status = ST_DIV0;
		end else if (fin.op == OP_DIV) begin
			out_re     = fre.val;
			out_im     = fim.val;
			out_status = (fre.sat || fim.sat) ? ST_SAT : ST_OK;
		end else if (fin.op == OP_MAG) begin
			out_re     = fin.root[ROOT_BITS-1] ? WMAX[WORD_BITS-1:0] : fin.root;
			out_im     = '0;
			out_status = fin.root[ROOT_BITS-1] ? ST_SAT : ST_OK;
		end else begin
			out_re     = fin.qre;
			out_im     = fin.qim;
			out_status = fin.qsat ? ST_SAT : ST_OK;
		end
	end

	// checks
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(it_s3[NST-1]) && v_s3[NST-1])
		else $error("last stage changed while stalled");
	a_mag_im: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr && fin.op == OP_MAG |-> out_im == '0)
		else $error("magnitude with nonzero imaginary part");
	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr && fin.op == OP_DIV && fin.div0 |-> out_re == '0 && out_status == ST_DIV0)
		else $error("division by zero not reported");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1)
		else $error("product stage lost a word under stall");

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ---------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide, conjugate, negate and magnitude.
// ---------------------------------------------------------------------------
// Operands and results are signed Q15.16. A word is taken whenever push is
// high and full is low, one per cycle sustained while results are popped.
// It passes through products, sums, then 33 pipelined steps of the
// restoring divider that also carries the square-root digits. The result
// waits in a two-entry result queue until popped. A four-entry queue
// decouples intake from the execution pipeline, which stalls as a whole
// only while its last stage holds a result and the result queue is full.
// ---------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH,
	parameter int OUT_DEPTH_P   = OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  req_type,
	input  cau_word_t   a_re,
	input  cau_word_t   a_im,
	input  cau_word_t   b_re,
	input  cau_word_t   b_im,
	output logic        empty,
	input  logic        pop,
	output cau_word_t   res_re,
	output cau_word_t   res_im,
	output logic [1:0]  status
);

	localparam int OW = 2 * WORD_BITS + 2;

	logic        q_full, q_wr, q_empty, q_rd;
	cau_item_t   q_wdata, q_rdata;
	logic        o_full, o_wr;
	cau_word_t   o_re, o_im;
	cau_status_t o_st;
	logic [OW-1:0] o_rdata;

	// front: intake and decode
	cau_front u_front (
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_item   (q_wdata)
	);

	// queue between front and back
	cau_fifo #(.WIDTH($bits(cau_item_t)), .DEPTH(QUEUE_DEPTH_P)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back: execution pipeline
	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_empty   (q_empty),
		.in_item    (q_rdata),
		.in_rd      (q_rd),
		.out_full   (o_full),
		.out_wr     (o_wr),
		.out_re     (o_re),
		.out_im     (o_im),
		.out_status (o_st)
	);

	// result queue
	cau_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH_P)) u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (o_wr),
		.wdata  ({o_re, o_im, o_st}),
		.full   (o_full),
		.rd     (pop),
		.rdata  (o_rdata),
		.empty  (empty)
	);

	assign res_re = o_rdata[OW-1 -: WORD_BITS];
	assign res_im = o_rdata[WORD_BITS+1 -: WORD_BITS];
	assign status = o_rdata[1:0];

endmodule

`default_nettype wire
